### hw/rtl/i2ctbe_pkg.sv
// shared types, constants and helpers of the i2c target buffer engine
`timescale 1ns / 1ps

package i2ctbe_pkg;

  // buffer geometry
  localparam int unsigned BufSize = 8;
  localparam int unsigned PtrW    = $clog2(BufSize);
  localparam int unsigned LastIdx = BufSize - 1;

  // field widths
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned HostIdxW = 3;
  localparam int unsigned MarkerW = 2;

  // stream widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  // classified bus and host events
  typedef enum logic [FuncW-1:0] {
    FuncAddrWrite = 3'd0,
    FuncByteRx    = 3'd1,
    FuncTxReq     = 3'd2,
    FuncStop      = 3'd3,
    FuncHostLoad  = 3'd4,
    FuncHostRead  = 3'd5
  } func_e;

  // receive marker codes
  typedef enum logic [MarkerW-1:0] {
    MarkEvent  = 2'd0,
    MarkStored = 2'd1,
    MarkEnd    = 2'd2
  } marker_e;

  // per-item info held between the update stage and the output stage
  typedef struct packed {
    logic               ack;
    marker_e            marker;
    logic               pause;
    logic [ByteW-1:0]   mode_flag;
    logic               tx_rd;
    logic               rx_rd;
    logic [PtrW-1:0]    addr;
  } s1_t;

  // tx store contents after reset; entries past the eighth are zero
  function automatic logic [ByteW-1:0] tx_init(input logic [PtrW-1:0] idx);
    logic [ByteW-1:0] val;
    val = '0;
    if (32'(idx) < 32'd8) begin
      case (32'(idx))
        32'd0:   val = 8'h01;
        32'd1:   val = 8'h03;
        32'd2:   val = 8'h07;
        32'd3:   val = 8'h0F;
        32'd4:   val = 8'h80;
        32'd5:   val = 8'hC0;
        32'd6:   val = 8'hE0;
        32'd7:   val = 8'hF0;
        default: val = '0;
      endcase
    end
    return val;
  endfunction

endpackage

### hw/rtl/i2ctbe_ram.sv
// generic one-write one-read ram with registered read and per-entry written bits
`timescale 1ns / 1ps

module i2ctbe_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o,
  output logic                     rwritten_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] written_q;
  logic [Width-1:0] rdata_q;
  logic             rwritten_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // written bits, cleared at reset so unwritten entries read as their default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rwritten_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o    = rdata_q;
  assign rwritten_o = rwritten_q;

endmodule

### hw/rtl/i2ctbe_ctrl.sv
// pointer and mode flag update, store access issue and first pipeline stage
`timescale 1ns / 1ps

module i2ctbe_ctrl
  import i2ctbe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FuncW-1:0]    func_i,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic [HostIdxW-1:0] host_index_i,
  input  logic                s1_take_i,
  output logic                s1_valid_o,
  output s1_t                 s1_o,
  output logic                rx_we_o,
  output logic                rx_re_o,
  output logic                tx_we_o,
  output logic                tx_re_o,
  output logic [PtrW-1:0]     rx_waddr_o,
  output logic [PtrW-1:0]     tx_waddr_o,
  output logic [PtrW-1:0]     rd_addr_o,
  output logic [ByteW-1:0]    wdata_o
);

  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic             ptr_valid_q, ptr_valid_d;
  logic [ByteW-1:0] flag_q, flag_d;
  logic             s1_valid_q;
  s1_t              s1_q, s1_d;
  logic             accept;
  logic [PtrW-1:0]  eff_ptr;
  logic [PtrW:0]    inc;
  logic             at_end;
  logic             host_in_range;
  logic [PtrW-1:0]  host_addr;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [PtrW-1:0]  rd_addr;

  assign in_ready_o = !s1_valid_q || s1_take_i;
  assign accept     = in_valid_i && in_ready_o;

  // pointer arithmetic, an undefined pointer counts from entry zero
  assign eff_ptr       = ptr_valid_q ? ptr_q : '0;
  assign inc           = {1'b0, eff_ptr} + (PtrW+1)'(1);
  assign at_end        = inc >= (PtrW+1)'(LastIdx);
  assign host_in_range = 32'(host_index_i) < BufSize;
  assign host_addr     = PtrW'(host_index_i);

  // event decode
  always_comb begin
    ptr_d        = ptr_q;
    ptr_valid_d  = ptr_valid_q;
    flag_d       = flag_q;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    rd_addr      = host_addr;
    s1_d         = '0;
    s1_d.marker  = MarkEvent;
    unique case (func_i)
      FuncAddrWrite: begin
        s1_d.ack = 1'b1;
      end
      FuncByteRx: begin
        if (!ptr_valid_q) begin
          flag_d      = data_byte_i;
          ptr_d       = '0;
          ptr_valid_d = 1'b1;
          s1_d.ack    = 1'b1;
        end else begin
          rx_we = 1'b1;
          if (at_end) begin
            ptr_d       = '0;
            ptr_valid_d = 1'b0;
            s1_d.ack    = 1'b0;
            s1_d.marker = MarkEnd;
          end else begin
            ptr_d       = inc[PtrW-1:0];
            s1_d.ack    = 1'b1;
            s1_d.marker = MarkStored;
          end
        end
      end
      FuncTxReq: begin
        tx_re      = 1'b1;
        rd_addr    = eff_ptr;
        s1_d.tx_rd = 1'b1;
        if (at_end) begin
          ptr_d       = '0;
          ptr_valid_d = 1'b0;
          s1_d.ack    = 1'b0;
        end else begin
          ptr_d       = inc[PtrW-1:0];
          ptr_valid_d = 1'b1;
          s1_d.ack    = 1'b1;
        end
      end
      FuncHostLoad: begin
        tx_we = host_in_range;
      end
      FuncHostRead: begin
        rx_re      = host_in_range;
        s1_d.rx_rd = host_in_range;
      end
      default: begin
        s1_d.ack   = 1'b1;
        s1_d.pause = 1'b1;
      end
    endcase
    s1_d.mode_flag = flag_d;
    s1_d.addr      = rd_addr;
  end

  // architectural state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      ptr_valid_q <= 1'b0;
      flag_q      <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        ptr_q       <= ptr_d;
        ptr_valid_q <= ptr_valid_d;
        flag_q      <= flag_d;
        s1_valid_q  <= 1'b1;
      end else if (s1_take_i) begin
        s1_valid_q  <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;
  assign rx_we_o    = accept && rx_we;
  assign rx_re_o    = accept && rx_re;
  assign tx_we_o    = accept && tx_we;
  assign tx_re_o    = accept && tx_re;
  assign rx_waddr_o = ptr_q;
  assign tx_waddr_o = host_addr;
  assign rd_addr_o  = rd_addr;
  assign wdata_o    = data_byte_i;

endmodule

### hw/rtl/i2ctbe_out_stage.sv
// merges store read data with stage info and holds the result for the receiver
`timescale 1ns / 1ps

module i2ctbe_out_stage
  import i2ctbe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s1_valid_i,
  input  s1_t                 s1_i,
  output logic                s1_take_o,
  input  logic [ByteW-1:0]    tx_rdata_i,
  input  logic                tx_rwritten_i,
  input  logic [ByteW-1:0]    rx_rdata_i,
  input  logic                rx_rwritten_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [ByteW-1:0]    send_byte;
  logic [ByteW-1:0]    read_data;

  assign s1_take_o = s1_valid_i && (!out_valid_q || out_ready_i);

  // unwritten entries read as their reset contents
  always_comb begin
    send_byte = '0;
    read_data = '0;
    if (s1_i.tx_rd) begin
      send_byte = tx_rwritten_i ? tx_rdata_i : tx_init(s1_i.addr);
    end
    if (s1_i.rx_rd && rx_rwritten_i) begin
      read_data = rx_rdata_i;
    end
    out_data_d = {4'b0, read_data, s1_i.pause, s1_i.marker, s1_i.mode_flag,
                  send_byte, s1_i.ack};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/i2ctbe_checker.sv
// port-level checker for the i2c target buffer engine, bound to the top level
`timescale 1ns / 1ps

module i2ctbe_checker
  import i2ctbe_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // transactions taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // a result is offered only for an item taken earlier
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 3'd0)
    else $error("result offered with no item outstanding");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  // stop events always acknowledge
  a_pause_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tdata[0] && m_axis_tdata[18:17] == 2'd0)
    else $error("pause without ack");

  // buffer end on receive means nack
  a_end_nack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18:17] == 2'd2 |-> !m_axis_tdata[0])
    else $error("buffer end acknowledged");

  // host read data only comes with a host item
  a_read_host: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[27:20] != 8'd0 |-> !m_axis_tdata[0]
      && m_axis_tdata[8:1] == 8'd0)
    else $error("read data on a bus event");

endmodule

bind i2c_target_buffer_engine_core i2ctbe_checker u_i2ctbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### hw/rtl/i2c_target_buffer_engine_core.sv
// I2C target buffer engine: bus event reaction with rx/tx stores and auto-increment
//
// Usage:
//   The slave stream carries one classified event per transaction: the event
//   code in tuser, the received or host byte and the host entry index in tdata.
//   Every event gives exactly one result on the master stream: ack/nack, the
//   byte to send, the current mode flag, the receive marker, pause and the
//   host read data, packed in tdata.
//   Each accepted event is registered first in the update stage, which
//   holds the pointer update and issues the store access, and then in the
//   output register, which merges in the store read data. A new event is
//   taken every cycle while the receiver keeps taking results.
//   Reset clears the pointer (undefined), the mode flag and the written bits
//   of both stores, so the rx store reads zero and the tx store reads its
//   default pattern; no clearing pass is needed.
//   When the receiver stalls, the result waits in the output register while
//   one more event can enter the update stage; after that the input stalls.
`timescale 1ns / 1ps

module i2c_target_buffer_engine_core
  import i2ctbe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] data_byte, [10:8] host_index, [15:11] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [2:0] func
  input  logic [FuncW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] ack_next, [8:1] send_byte, [16:9] mode_flag, [18:17] rx_marker,
  // [19] pause, [27:20] read_data, [31:28] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic             s1_take;
  logic             s1_valid;
  s1_t              s1;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [PtrW-1:0]  rx_waddr, tx_waddr, rd_addr;
  logic [ByteW-1:0] wdata;
  logic [ByteW-1:0] rx_rdata, tx_rdata;
  logic             rx_rwritten, tx_rwritten;

  // event decode and pointer state
  i2ctbe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (s_axis_tuser),
    .data_byte_i  (s_axis_tdata[7:0]),
    .host_index_i (s_axis_tdata[10:8]),
    .s1_take_i    (s1_take),
    .s1_valid_o   (s1_valid),
    .s1_o         (s1),
    .rx_we_o      (rx_we),
    .rx_re_o      (rx_re),
    .tx_we_o      (tx_we),
    .tx_re_o      (tx_re),
    .rx_waddr_o   (rx_waddr),
    .tx_waddr_o   (tx_waddr),
    .rd_addr_o    (rd_addr),
    .wdata_o      (wdata)
  );

  // receive store
  i2ctbe_ram #(
    .Depth (BufSize),
    .Width (ByteW)
  ) u_rx_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (rx_we),
    .waddr_i    (rx_waddr),
    .wdata_i    (wdata),
    .re_i       (rx_re),
    .raddr_i    (rd_addr),
    .rdata_o    (rx_rdata),
    .rwritten_o (rx_rwritten)
  );

  // transmit store
  i2ctbe_ram #(
    .Depth (BufSize),
    .Width (ByteW)
  ) u_tx_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (tx_we),
    .waddr_i    (tx_waddr),
    .wdata_i    (wdata),
    .re_i       (tx_re),
    .raddr_i    (rd_addr),
    .rdata_o    (tx_rdata),
    .rwritten_o (tx_rwritten)
  );

  // result assembly and output register
  i2ctbe_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_i          (s1),
    .s1_take_o     (s1_take),
    .tx_rdata_i    (tx_rdata),
    .tx_rwritten_i (tx_rwritten),
    .rx_rdata_i    (rx_rdata),
    .rx_rwritten_i (rx_rwritten),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule
